FILE: hdl/idle_time_accumulator_macros.svh
// Assertion macros shared by the idle time accumulator RTL
`ifndef IDLE_TIME_ACCUMULATOR_MACROS_SVH
`define IDLE_TIME_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ITA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ita assertion failed in %m");

// Next-cycle implication, checked outside reset
`define ITA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ita assertion failed in %m");

`endif

FILE: hdl/ita_pkg.sv
// Types, codes and helpers for the idle time accumulator
`default_nettype none

package ita_pkg;

    localparam int IN_W  = 40;
    localparam int OUT_W = 264;

    // action codes
    localparam logic [1:0] ACT_IDLE_BEGIN = 2'd0;
    localparam logic [1:0] ACT_IDLE_END   = 2'd1;
    localparam logic [1:0] ACT_SNAPSHOT   = 2'd2;

    // status codes
    localparam logic [1:0] ST_WARM_UNAVAIL = 2'd0;
    localparam logic [1:0] ST_WARMING      = 2'd1;
    localparam logic [1:0] ST_VALID        = 2'd2;
    localparam logic [1:0] ST_UNAVAIL      = 2'd3;

    localparam logic [31:0] CNT32_MAX = 32'hFFFF_FFFF;
    localparam logic [63:0] CNT64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] tick;
        logic        sample_ok;
    } item_t;

    typedef struct packed {
        logic        have_ref;
        logic [31:0] ref_tick;
        logic [63:0] total;
        logic [63:0] idle;
        logic [31:0] epoch;
        logic [31:0] errors;
        logic [31:0] changes;
        logic        open;
        logic [31:0] freq;
        logic [1:0]  status;
    } state_t;

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        return (v == CNT32_MAX) ? v : v + 32'd1;
    endfunction

    function automatic item_t unpack_item(input logic [IN_W-1:0] d);
        item_t it;
        it.action    = d[1:0];
        it.tick      = d[33:2];
        it.sample_ok = d[34];
        return it;
    endfunction

    function automatic logic [OUT_W-1:0] pack_result(input state_t s);
        return {5'd0, s.open, s.changes, s.errors, s.idle, s.total,
                s.freq, s.epoch, s.status};
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ita_in_stage.sv
// Input register stage: holds one request until the update stage takes it
`default_nettype none

module ita_in_stage (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [ita_pkg::IN_W-1:0]  s_axis_tdata,
    input  wire logic                      take,
    output logic                           item_valid,
    output ita_pkg::item_t                 item
);

    logic           valid_reg;
    logic           valid_next;
    ita_pkg::item_t item_reg;

    assign s_axis_tready = !valid_reg || take;
    assign valid_next    = (s_axis_tvalid && s_axis_tready) ? 1'b1
                         : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg <= ita_pkg::unpack_item(s_axis_tdata);
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

FILE: hdl/ita_update.sv
// Next-state logic: applies one event to the accumulator state
`default_nettype none

module ita_update (
    input  wire ita_pkg::state_t cur,
    input  wire ita_pkg::item_t  item,
    input  wire logic [31:0]     nominal,
    output ita_pkg::state_t      nxt
);

    logic        is_edge;
    logic        take;
    logic [31:0] delta;
    logic        bad;
    logic [64:0] total_sum;
    logic [64:0] idle_sum;
    logic [63:0] total_sat;
    logic [63:0] idle_sat;

    // begin/end only sample when they actually flip the open state
    assign is_edge = ((item.action == ita_pkg::ACT_IDLE_BEGIN) && !cur.open) ||
                     ((item.action == ita_pkg::ACT_IDLE_END) && cur.open);
    assign take    = is_edge || (item.action == ita_pkg::ACT_SNAPSHOT);

    assign delta = item.tick - cur.ref_tick;
    assign bad   = !item.sample_ok || (cur.have_ref && delta[31]);

    assign total_sum = {1'b0, cur.total} + {33'd0, delta};
    assign idle_sum  = {1'b0, cur.idle} + {33'd0, delta};
    assign total_sat = total_sum[64] ? ita_pkg::CNT64_MAX : total_sum[63:0];
    assign idle_sat  = idle_sum[64] ? ita_pkg::CNT64_MAX : idle_sum[63:0];

    always_comb
    begin
        nxt = cur;
        if (take)
        begin
            if (bad)
            begin
                nxt.errors   = ita_pkg::sat_inc32(cur.errors);
                nxt.have_ref = 1'b0;
                nxt.freq     = 32'd0;
                nxt.total    = 64'd0;
                nxt.idle     = 64'd0;
                nxt.status   = ita_pkg::ST_UNAVAIL;
            end
            else if (!cur.have_ref)
            begin
                nxt.epoch    = ita_pkg::sat_inc32(cur.epoch);
                nxt.have_ref = 1'b1;
                nxt.ref_tick = item.tick;
                nxt.total    = 64'd0;
                nxt.idle     = 64'd0;
                nxt.freq     = nominal;
                nxt.status   = ita_pkg::ST_WARMING;
            end
            else
            begin
                nxt.ref_tick = item.tick;
                nxt.total    = total_sat;
                if (cur.open)
                begin
                    nxt.idle = idle_sat;
                end
                if (total_sat != 64'd0)
                begin
                    nxt.status = ita_pkg::ST_VALID;
                end
            end
        end
        if (is_edge)
        begin
            nxt.open    = (item.action == ita_pkg::ACT_IDLE_BEGIN);
            nxt.changes = ita_pkg::sat_inc32(cur.changes);
        end
    end

endmodule

`default_nettype wire

FILE: hdl/idle_time_accumulator.sv
// Idle time accumulator: busy/idle tick counting from a free-running 32-bit timer.
// Each request (idle begin, idle end or snapshot, with a timer sample and a
// qualify flag) is captured in an input register, applied to the counter state
// and the resulting state is presented in an output register. One request is
// taken every cycle while the output is not stalled; the rate is set by the
// combinational state update loop (a 32-bit wrapping delta feeding two 64-bit
// saturating adders). While a result waits at the output, the input register
// takes one more request and then the input stalls until the result is taken.
// The nominal frequency register may be written only while no request is in
// flight.
`default_nettype none

module idle_time_accumulator (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [31:0]               cfg_wr_data,   // nominal timer frequency
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // action[1:0], tick[33:2], sample_ok[34], zero fill
    input  wire logic [ita_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // status[1:0], epoch[33:2], freq[65:34], total_ticks[129:66],
    // idle_ticks[193:130], errors[225:194], transitions[257:226],
    // idle_open[258], zero fill
    output logic [ita_pkg::OUT_W-1:0]      m_axis_tdata
);

    `include "idle_time_accumulator_macros.svh"

    logic                       item_valid;
    ita_pkg::item_t             item;
    logic                       advance;
    logic [31:0]                nominal_reg;
    ita_pkg::state_t            state_reg;
    ita_pkg::state_t            state_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [ita_pkg::OUT_W-1:0]  out_data_reg;

    assign advance = item_valid && (!out_valid_reg || m_axis_tready);

    ita_in_stage u_in (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .take          (advance),
        .item_valid    (item_valid),
        .item          (item)
    );

    ita_update u_upd (
        .cur     (state_reg),
        .item    (item),
        .nominal (nominal_reg),
        .nxt     (state_next)
    );

    assign out_valid_next = advance ? 1'b1
                          : ((out_valid_reg && m_axis_tready) ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nominal_reg   <= 32'd0;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                nominal_reg <= cfg_wr_data;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= ita_pkg::pack_result(state_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `ITA_ASSERT_IMPL(a_unavail_no_freq, clk, rst_n,
        m_axis_tvalid && (m_axis_tdata[1:0] == ita_pkg::ST_UNAVAIL),
        m_axis_tdata[65:34] == 32'd0)
    `ITA_ASSERT_IMPL(a_ref_means_available, clk, rst_n,
        state_reg.have_ref,
        (state_reg.status == ita_pkg::ST_WARMING) || (state_reg.status == ita_pkg::ST_VALID))
    `ITA_ASSERT_IMPL(a_idle_within_total, clk, rst_n,
        1'b1,
        state_reg.idle <= state_reg.total)
    `ITA_ASSERT_NEXT(a_state_holds, clk, rst_n,
        !advance,
        $stable(state_reg))

endmodule

`default_nettype wire

FILE: sim/idle_time_checker.sv
// Checker for the idle time accumulator: predicts each report and compares it field by field
module idle_time_checker (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [31:0]              cfg_wr_data,
    input  logic                     req_valid,
    input  logic                     req_ready,
    input  logic [ita_pkg::IN_W-1:0] req_data,
    input  logic                     rpt_valid,
    input  logic                     rpt_ready,
    input  logic [ita_pkg::OUT_W-1:0] rpt_data,
    output int                       mismatches,
    output int                       outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import ita_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] epoch;
        logic [31:0] freq;
        logic [63:0] total;
        logic [63:0] idle;
        logic [31:0] errors;
        logic [31:0] changes;
        logic        open;
    } report_t;

    report_t     expected_reports[$];
    int          fail_tally;

    // predicted block state
    logic [31:0] nominal_freq;
    logic        ref_valid;
    logic [31:0] ref_tick;
    logic [63:0] total_ticks;
    logic [63:0] idle_ticks;
    logic [31:0] epoch_cnt;
    logic [31:0] error_cnt;
    logic [31:0] change_cnt;
    logic        idle_open;
    logic [31:0] shown_freq;
    logic [1:0]  status;

    function automatic logic [31:0] bump32(input logic [31:0] v);
        return (v == CNT32_MAX) ? v : v + 32'd1;
    endfunction

    function automatic logic [63:0] add64_sat(input logic [63:0] a, input logic [31:0] b);
        logic [64:0] sum;
        sum = {1'b0, a} + {33'd0, b};
        return sum[64] ? CNT64_MAX : sum[63:0];
    endfunction

    task automatic drop_epoch();
        error_cnt   = bump32(error_cnt);
        ref_valid   = 1'b0;
        shown_freq  = 32'd0;
        total_ticks = 64'd0;
        idle_ticks  = 64'd0;
        status      = ST_UNAVAIL;
    endtask

    task automatic take_tick_sample(input logic [31:0] tick, input logic ok);
        logic [31:0] delta;
        delta = tick - ref_tick;
        if (!ok) begin
            drop_epoch();
        end
        else if (!ref_valid) begin
            epoch_cnt   = bump32(epoch_cnt);
            ref_valid   = 1'b1;
            ref_tick    = tick;
            total_ticks = 64'd0;
            idle_ticks  = 64'd0;
            shown_freq  = nominal_freq;
            status      = ST_WARMING;
        end
        else if (delta[31]) begin
            drop_epoch();
        end
        else begin
            ref_tick    = tick;
            total_ticks = add64_sat(total_ticks, delta);
            if (idle_open)
                idle_ticks = add64_sat(idle_ticks, delta);
            if (total_ticks != 64'd0)
                status = ST_VALID;
        end
    endtask

    task automatic apply_event(input logic [1:0] act, input logic [31:0] tick, input logic ok);
        report_t rpt;
        logic    want_open;
        want_open = (act == ACT_IDLE_BEGIN);
        if (act == ACT_IDLE_BEGIN || act == ACT_IDLE_END) begin
            // redundant begin/end takes no sample at all
            if (idle_open != want_open) begin
                take_tick_sample(tick, ok);
                idle_open  = want_open;
                change_cnt = bump32(change_cnt);
            end
        end
        else if (act == ACT_SNAPSHOT) begin
            take_tick_sample(tick, ok);
        end
        rpt.status  = status;
        rpt.epoch   = epoch_cnt;
        rpt.freq    = shown_freq;
        rpt.total   = total_ticks;
        rpt.idle    = idle_ticks;
        rpt.errors  = error_cnt;
        rpt.changes = change_cnt;
        rpt.open    = idle_open;
        expected_reports.push_back(rpt);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            fail_tally++;
        end
    endtask

    task automatic check_report(input logic [OUT_W-1:0] d);
        report_t want;
        if (expected_reports.size() == 0) begin
            $display("%0t: unexpected report, expected none, actual %h", $time, d);
            fail_tally++;
        end
        else begin
            want = expected_reports.pop_front();
            check_field("status",       64'(want.status),  64'(d[1:0]));
            check_field("epoch",        64'(want.epoch),   64'(d[33:2]));
            check_field("freq",         64'(want.freq),    64'(d[65:34]));
            check_field("total_ticks",  want.total,        d[129:66]);
            check_field("idle_ticks",   want.idle,         d[193:130]);
            check_field("errors",       64'(want.errors),  64'(d[225:194]));
            check_field("transitions",  64'(want.changes), 64'(d[257:226]));
            check_field("idle_open",    64'(want.open),    64'(d[258]));
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            nominal_freq = 32'd0;
            ref_valid    = 1'b0;
            ref_tick     = 32'd0;
            total_ticks  = 64'd0;
            idle_ticks   = 64'd0;
            epoch_cnt    = 32'd0;
            error_cnt    = 32'd0;
            change_cnt   = 32'd0;
            idle_open    = 1'b0;
            shown_freq   = 32'd0;
            status       = ST_WARM_UNAVAIL;
            fail_tally   = 0;
            expected_reports.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else begin
            if (cfg_wr_en)
                nominal_freq = cfg_wr_data;
            // compare first so a stray report never eats this cycle's prediction
            if (rpt_valid && rpt_ready)
                check_report(rpt_data);
            if (req_valid && req_ready)
                apply_event(req_data[1:0], req_data[33:2], req_data[34]);
            mismatches  <= fail_tally;
            outstanding <= expected_reports.size();
        end
    end

endmodule

FILE: sim/idle_time_accumulator_tb.sv
// Top of the idle time accumulator testbench: clock, reset, stimulus and verdict
module idle_time_accumulator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ita_pkg::*;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         QUIET_LIMIT = 4000;
    localparam int         PHASES      = 5;
    localparam int         RANDOM_PER_PHASE = 150;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [31:0]         cfg_wr_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;

    int                  mismatches;
    int                  outstanding;
    int                  quiet_cycles = 0;
    int                  burst_left = 1;
    int                  rx_mode = 0;
    int                  mode_left = 0;
    logic [31:0]         tb_tick;

    always #2 clk = ~clk;

    idle_time_accumulator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    idle_time_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req_data    (s_tdata),
        .rpt_valid   (m_tvalid),
        .rpt_ready   (m_tready),
        .rpt_data    (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // receiver: switches between free flow, light, heavy and periodic stalls
    always @(posedge clk) begin
        if (mode_left == 0) begin
            rx_mode   <= $urandom_range(0, 3);
            mode_left <= $urandom_range(20, 200);
        end
        else begin
            mode_left <= mode_left - 1;
        end
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (mode_left % 5 == 0);
        endcase
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end
            else begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    // one request, sent in bursts with random gaps
    task automatic push_request(input logic [1:0] act, input logic [31:0] tick, input logic ok);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, ok, tick, act};
        do @(posedge clk); while (!s_tready);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_random_event();
        int          pick;
        int          act_pick;
        logic [31:0] delta;
        logic [1:0]  act;
        logic        ok;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            delta = 32'd0;
        else if (pick < 55)
            delta = $urandom_range(1, 255);
        else if (pick < 80)
            delta = $urandom_range(256, 32'h000F_FFFF);
        else if (pick < 91)
            delta = $urandom_range(0, 32'h7FFF_FFFF);
        else if (pick < 94)
            delta = 32'h7FFF_FFFF;
        else if (pick < 97)
            delta = 32'h8000_0000;
        else
            delta = $urandom_range(32'h8000_0001, 32'hFFFF_FFFF);
        act_pick = $urandom_range(0, 19);
        if (act_pick == 0)
            act = ACT_UNUSED;
        else if (act_pick < 7)
            act = ACT_IDLE_BEGIN;
        else if (act_pick < 13)
            act = ACT_IDLE_END;
        else
            act = ACT_SNAPSHOT;
        ok = ($urandom_range(0, 15) != 0);
        tb_tick = tb_tick + delta;
        push_request(act, tb_tick, ok);
    endtask

    // drop valid, wait out every report plus the pipeline depth
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    initial begin
        logic [31:0] freq_plan [PHASES];
        logic [31:0] t;
        freq_plan[0] = 32'hFFFF_FFFF;
        freq_plan[1] = 32'd0;
        freq_plan[2] = $urandom;
        freq_plan[3] = 32'd1;
        freq_plan[4] = $urandom;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 32'd0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        tb_tick     = 32'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < PHASES; p++) begin
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= freq_plan[p];
            @(posedge clk);
            cfg_wr_en   <= 1'b0;

            if (p == 0) begin
                push_request(ACT_UNUSED, 32'd0, 1'b1);
                push_request(ACT_IDLE_END, 32'd0, 1'b1);      // already closed
                push_request(ACT_SNAPSHOT, 32'hFFFF_FFFF, 1'b0);
                push_request(ACT_SNAPSHOT, 32'd0, 1'b1);      // epoch start
                push_request(ACT_SNAPSHOT, 32'd0, 1'b1);      // zero delta, still warming
                push_request(ACT_IDLE_BEGIN, 32'd100, 1'b1);
                push_request(ACT_IDLE_BEGIN, 32'd200, 1'b1);  // already open
                t = 32'd100 + 32'h7FFF_FFFF;
                push_request(ACT_SNAPSHOT, t, 1'b1);          // largest legal delta
                t = t + 32'h8000_0000;
                push_request(ACT_SNAPSHOT, t, 1'b1);          // delta rejected
                push_request(ACT_IDLE_END, 32'hFFFF_FFF0, 1'b0);
                push_request(ACT_SNAPSHOT, 32'hFFFF_FFF0, 1'b1);
                push_request(ACT_IDLE_BEGIN, 32'h0000_0010, 1'b1); // wraps
                push_request(ACT_SNAPSHOT, 32'h0000_0030, 1'b1);
                push_request(ACT_UNUSED, 32'hFFFF_FFFF, 1'b0);
                push_request(ACT_IDLE_END, 32'h0000_0040, 1'b1);
                push_request(ACT_IDLE_END, 32'h0000_0050, 1'b0);
                push_request(ACT_SNAPSHOT, 32'hFFFF_FFFF, 1'b1);
                push_request(ACT_IDLE_BEGIN, 32'h0000_1234, 1'b1);
                t = 32'h0000_1234;
                repeat (3) begin
                    t = t + 32'h7FFF_FFFF;
                    push_request(ACT_SNAPSHOT, t, 1'b1);
                end
                push_request(ACT_IDLE_END, t + 32'd1, 1'b1);
                push_request(ACT_IDLE_BEGIN, t + 32'd2, 1'b0);
                push_request(ACT_SNAPSHOT, t + 32'd3, 1'b1);
                tb_tick = t + 32'd3;
            end

            repeat (RANDOM_PER_PHASE) send_random_event();
            settle();
        end

        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS");
        end
        else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
